// File: design/maze_dfs_backtracker_unit_defines.svh
// Assertion macros shared by the maze generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MAZE_DFS_BACKTRACKER_UNIT_DEFINES_SVH
`define MAZE_DFS_BACKTRACKER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MDB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define MDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition holds at every clock edge outside reset.
`define MDB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

// File: design/mdb_pkg.sv
// Package of the maze generator: codes, payload types and the control bundles.
// Depends on nothing; used by mdb_datapath, mdb_controller, the top level and the testbench.
package mdb_pkg;

	localparam int DEF_MAX_SIDE = 32;
	localparam logic [5:0] SIDE_RESET = 6'd32;

	localparam logic REG_SIDE_LENGTH = 1'b0;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [2:0] EV_IGNORED  = 3'd0;
	localparam logic [2:0] EV_CARVED   = 3'd1;
	localparam logic [2:0] EV_BACK     = 3'd2;
	localparam logic [2:0] EV_FINISHED = 3'd3;
	localparam logic [2:0] EV_CLEARED  = 3'd4;
	localparam logic [2:0] EV_READ     = 3'd5;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	localparam logic [3:0] ALL_WALLS = 4'hf;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] random_word;
		logic [4:0]  read_x;
		logic [4:0]  read_y;
	} req_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [1:0] direction;
		logic [3:0] walls;
		logic       done_res;
	} rsp_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_CUR_LEFT,
		RD_RIGHT_UP,
		RD_DOWN,
		RD_CELL
	} rd_sel_t;

	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_CUR_LEFT,
		CAP_RIGHT_UP,
		CAP_DOWN
	} cap_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLEAR,
		WR_CUR,
		WR_NBR
	} wr_sel_t;

	typedef struct packed {
		logic       load_item;
		logic       init;
		rd_sel_t    rd_sel;
		cap_sel_t   cap_sel;
		wr_sel_t    wr_sel;
		logic       eval;
		logic       pop_rd;
		logic       pop_ld;
		logic       set_fin;
		logic       out_load;
		logic [2:0] ev;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       running;
		logic       finished;
		logic       read_hit;
		logic       any_opt;
		logic       stack_empty;
		logic       clear_last;
		logic       out_busy;
	} dp_status_t;

endpackage

// File: design/mdb_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing; the payload type is given by the instance.
interface mdb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/mdb_datapath.sv
// Datapath of the maze generator: cell store, path stack, current cell and result register.
// Depends on mdb_pkg and the assertion macro header; driven by mdb_controller.
`include "maze_dfs_backtracker_unit_defines.svh"

module mdb_datapath #(
	parameter int MAX_SIDE = mdb_pkg::DEF_MAX_SIDE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mdb_pkg::ctrl_cmd_t     cmd,
	output mdb_pkg::dp_status_t    status,
	input  logic [5:0]             side_length,
	input  mdb_pkg::req_t          req_data,
	output mdb_pkg::rsp_t          rsp_data,
	output logic                   rsp_valid,
	input  logic                   rsp_ready
);

	localparam int CW    = $clog2(MAX_SIDE);
	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int IW    = $clog2(CELLS);
	localparam int DW    = $clog2(CELLS + 1);
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int CMPW  = (SW > 6) ? SW : 6;
	localparam logic [IW-1:0] ROW = IW'(MAX_SIDE);

	function automatic logic [IW-1:0] cell_idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
		return IW'(IW'(y) * ROW) + IW'(x);
	endfunction

	function automatic logic [1:0] mod3_word(input logic [31:0] v);
		logic [3:0] part [4];
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		for (int g = 0; g < 4; g++) begin
			part[g] = 4'(v[8*g +: 2]) + 4'(v[8*g+2 +: 2]) + 4'(v[8*g+4 +: 2])
				+ 4'(v[8*g+6 +: 2]);
		end
		s1 = 6'(part[0]) + 6'(part[1]) + 6'(part[2]) + 6'(part[3]);
		s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
		s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
		if (s3 >= 3'd3) begin
			s3 = s3 - 3'd3;
		end
		return s3[1:0];
	endfunction

	function automatic logic [1:0] pick_dir(input logic [3:0] mask, input logic [1:0] k);
		logic [2:0] seen;
		logic [1:0] sel;
		seen = '0;
		sel  = '0;
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				if (seen == {1'b0, k}) begin
					sel = 2'(i);
				end
				seen = seen + 3'd1;
			end
		end
		return sel;
	endfunction

	logic [1:0]      command_q;
	logic [31:0]     rnd_q;
	logic [4:0]      rx_q;
	logic [4:0]      ry_q;
	logic [1:0]      mod3_q;
	logic [SW-1:0]   active_side_q;
	logic [CW-1:0]   cur_x_q;
	logic [CW-1:0]   cur_y_q;
	logic [DW-1:0]   depth_q;
	logic            running_q;
	logic            finished_q;
	logic [IW-1:0]   clr_q;
	logic [4:0]      cw_q;
	logic [4:0]      lw_q;
	logic [4:0]      rw_q;
	logic [4:0]      uw_q;
	logic [4:0]      dw_q;
	logic [1:0]      dir_q;
	logic            any_q;
	logic            out_valid_q;
	mdb_pkg::rsp_t   out_q;

	logic [4:0]      cells [CELLS];
	logic [4:0]      rdata0_q;
	logic [4:0]      rdata1_q;
	logic [2*CW-1:0] stack_mem [CELLS];
	logic [2*CW-1:0] stk_rdata_q;

	logic [SW-1:0]   side_clamped;
	logic [CMPW-1:0] side_ext;
	logic [IW-1:0]   cur_idx;
	logic [IW-1:0]   read_idx;
	logic [IW-1:0]   nbr_idx;
	logic [4:0]      nbr_walls;
	logic            read_hit;
	logic [3:0]      mask;
	logic [2:0]      opt_count;
	logic [1:0]      opt_k;
	logic            rd_en;
	logic [IW-1:0]   rd_addr0;
	logic [IW-1:0]   rd_addr1;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	logic [4:0]      wr_data;
	logic [DW-1:0]   pop_addr;
	logic            push_ok;

	always_comb begin
		side_ext = CMPW'(side_length);
		if (side_ext == '0) begin
			side_clamped = SW'(1);
		end else if (side_ext > CMPW'(MAX_SIDE)) begin
			side_clamped = SW'(MAX_SIDE);
		end else begin
			side_clamped = SW'(side_ext);
		end
	end

	assign cur_idx  = cell_idx(cur_x_q, cur_y_q);
	assign read_idx = cell_idx(CW'(rx_q), CW'(ry_q));
	assign read_hit = (CMPW'(rx_q) < CMPW'(active_side_q))
		&& (CMPW'(ry_q) < CMPW'(active_side_q));

	always_comb begin
		mask[0] = cw_q[0] && (cur_x_q != '0) && !lw_q[4];
		mask[1] = cw_q[1] && ((CMPW'(cur_x_q) + CMPW'(1)) < CMPW'(active_side_q)) && !rw_q[4];
		mask[2] = cw_q[2] && (cur_y_q != '0) && !uw_q[4];
		mask[3] = cw_q[3] && ((CMPW'(cur_y_q) + CMPW'(1)) < CMPW'(active_side_q)) && !dw_q[4];
		opt_count = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
		case (opt_count)
			3'd2:    opt_k = {1'b0, rnd_q[0]};
			3'd3:    opt_k = mod3_q;
			3'd4:    opt_k = rnd_q[1:0];
			default: opt_k = 2'd0;
		endcase
	end

	always_comb begin
		case (dir_q)
			mdb_pkg::DIR_LEFT: begin
				nbr_idx   = cur_idx - IW'(1);
				nbr_walls = lw_q;
			end
			mdb_pkg::DIR_RIGHT: begin
				nbr_idx   = cur_idx + IW'(1);
				nbr_walls = rw_q;
			end
			mdb_pkg::DIR_UP: begin
				nbr_idx   = cur_idx - ROW;
				nbr_walls = uw_q;
			end
			default: begin
				nbr_idx   = cur_idx + ROW;
				nbr_walls = dw_q;
			end
		endcase
	end

	always_comb begin
		rd_en = 1'b1;
		case (cmd.rd_sel)
			mdb_pkg::RD_CUR_LEFT: begin
				rd_addr0 = cur_idx;
				rd_addr1 = cur_idx - IW'(1);
			end
			mdb_pkg::RD_RIGHT_UP: begin
				rd_addr0 = cur_idx + IW'(1);
				rd_addr1 = cur_idx - ROW;
			end
			mdb_pkg::RD_DOWN: begin
				rd_addr0 = cur_idx + ROW;
				rd_addr1 = cur_idx + ROW;
			end
			mdb_pkg::RD_CELL: begin
				rd_addr0 = read_idx;
				rd_addr1 = read_idx;
			end
			default: begin
				rd_en    = 1'b0;
				rd_addr0 = cur_idx;
				rd_addr1 = cur_idx;
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b1;
		case (cmd.wr_sel)
			mdb_pkg::WR_CLEAR: begin
				wr_addr = clr_q;
				wr_data = {(clr_q == '0), mdb_pkg::ALL_WALLS};
			end
			mdb_pkg::WR_CUR: begin
				wr_addr = cur_idx;
				wr_data = {cw_q[4], cw_q[3:0] & ~(4'b0001 << dir_q)};
			end
			mdb_pkg::WR_NBR: begin
				wr_addr = nbr_idx;
				wr_data = {1'b1, nbr_walls[3:0] & ~(4'b0001 << (dir_q ^ 2'b01))};
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = cur_idx;
				wr_data = cw_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cells[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata0_q <= cells[rd_addr0];
			rdata1_q <= cells[rd_addr1];
		end
	end

	assign pop_addr = depth_q - DW'(1);
	assign push_ok  = depth_q < DW'(CELLS);

	always_ff @(posedge clk) begin
		if ((cmd.wr_sel == mdb_pkg::WR_NBR) && push_ok) begin
			stack_mem[depth_q[IW-1:0]] <= {cur_y_q, cur_x_q};
		end
		if (cmd.pop_rd) begin
			stk_rdata_q <= stack_mem[pop_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		mod3_q <= mod3_word(rnd_q);
		if (cmd.load_item) begin
			command_q <= req_data.command;
			rnd_q     <= req_data.random_word;
			rx_q      <= req_data.read_x;
			ry_q      <= req_data.read_y;
		end
		case (cmd.cap_sel)
			mdb_pkg::CAP_CUR_LEFT: begin
				cw_q <= rdata0_q;
				lw_q <= rdata1_q;
			end
			mdb_pkg::CAP_RIGHT_UP: begin
				rw_q <= rdata0_q;
				uw_q <= rdata1_q;
			end
			mdb_pkg::CAP_DOWN: begin
				dw_q <= rdata0_q;
			end
			default: begin
			end
		endcase
		if (cmd.eval) begin
			dir_q <= pick_dir(mask, opt_k);
			any_q <= |mask;
		end
		if (cmd.out_load) begin
			out_q.event_res <= cmd.ev;
			out_q.cell_x    <= (cmd.ev == mdb_pkg::EV_READ) ? rx_q : 5'(cur_x_q);
			out_q.cell_y    <= (cmd.ev == mdb_pkg::EV_READ) ? ry_q : 5'(cur_y_q);
			out_q.direction <= (cmd.ev == mdb_pkg::EV_CARVED) ? dir_q : 2'd0;
			out_q.walls     <= ((cmd.ev == mdb_pkg::EV_READ) && read_hit) ? cw_q[3:0] : 4'd0;
			out_q.done_res  <= finished_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_side_q <= SW'(MAX_SIDE);
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			depth_q       <= '0;
			running_q     <= 1'b0;
			finished_q    <= 1'b0;
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.init) begin
				active_side_q <= side_clamped;
				cur_x_q       <= '0;
				cur_y_q       <= '0;
				depth_q       <= '0;
				running_q     <= 1'b1;
				finished_q    <= 1'b0;
				clr_q         <= '0;
			end
			if (cmd.wr_sel == mdb_pkg::WR_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.wr_sel == mdb_pkg::WR_NBR) begin
				if (push_ok) begin
					depth_q <= depth_q + DW'(1);
				end
				case (dir_q)
					mdb_pkg::DIR_LEFT:  cur_x_q <= cur_x_q - CW'(1);
					mdb_pkg::DIR_RIGHT: cur_x_q <= cur_x_q + CW'(1);
					mdb_pkg::DIR_UP:    cur_y_q <= cur_y_q - CW'(1);
					default:            cur_y_q <= cur_y_q + CW'(1);
				endcase
			end
			if (cmd.pop_rd) begin
				depth_q <= pop_addr;
			end
			if (cmd.pop_ld) begin
				{cur_y_q, cur_x_q} <= stk_rdata_q;
			end
			if (cmd.set_fin) begin
				finished_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.command     = command_q;
	assign status.running     = running_q;
	assign status.finished    = finished_q;
	assign status.read_hit    = read_hit;
	assign status.any_opt     = any_q;
	assign status.stack_empty = (depth_q == '0);
	assign status.clear_last  = (clr_q == IW'(CELLS - 1));
	assign status.out_busy    = out_valid_q && !rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	`MDB_ASSERT_ALWAYS(a_cur_in_grid, clk, arst_n, !running_q || ((CMPW'(cur_x_q) < CMPW'(active_side_q)) && (CMPW'(cur_y_q) < CMPW'(active_side_q))), "current cell lies outside the maze")
	`MDB_ASSERT_NEXT(a_push_depth, clk, arst_n, cmd.wr_sel == mdb_pkg::WR_NBR, depth_q == $past(depth_q) + DW'(1), "a carve did not deepen the path stack")
	`MDB_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, cmd.pop_rd, depth_q != '0, "backtrack popped an empty path stack")

endmodule

// File: design/mdb_controller.sv
// Sequencer of the maze generator: decodes each command beat and steps the datapath.
// Depends on mdb_pkg; drives mdb_datapath through the command bundle.
module mdb_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  mdb_pkg::dp_status_t  status,
	output mdb_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_CAP,
		S_EVAL,
		S_BRANCH,
		S_WR_CUR,
		S_WR_NBR,
		S_POP_RD,
		S_POP_LD,
		S_RD_CELL,
		S_CAP_CELL,
		S_RESP
	} state_t;

	state_t     state_q;
	logic       rdy_q;
	logic [2:0] ev_q;
	logic       accept;

	assign accept    = rdy_q && req_valid;
	assign req_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
			ev_q    <= mdb_pkg::EV_IGNORED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
						rdy_q   <= 1'b0;
					end
				end
				S_DECODE: begin
					case (status.command)
						mdb_pkg::CMD_START: begin
							ev_q    <= mdb_pkg::EV_CLEARED;
							state_q <= S_CLEAR;
						end
						mdb_pkg::CMD_STEP: begin
							if (!status.running) begin
								ev_q    <= mdb_pkg::EV_IGNORED;
								state_q <= S_RESP;
							end else if (status.finished) begin
								ev_q    <= mdb_pkg::EV_FINISHED;
								state_q <= S_RESP;
							end else begin
								state_q <= S_RD_A;
							end
						end
						mdb_pkg::CMD_READ: begin
							ev_q    <= mdb_pkg::EV_READ;
							state_q <= status.read_hit ? S_RD_CELL : S_RESP;
						end
						default: begin
							ev_q    <= mdb_pkg::EV_IGNORED;
							state_q <= S_RESP;
						end
					endcase
				end
				S_CLEAR: begin
					if (status.clear_last) begin
						state_q <= S_RESP;
					end
				end
				S_RD_A:     state_q <= S_RD_B;
				S_RD_B:     state_q <= S_RD_C;
				S_RD_C:     state_q <= S_CAP;
				S_CAP:      state_q <= S_EVAL;
				S_EVAL:     state_q <= S_BRANCH;
				S_BRANCH: begin
					if (status.any_opt) begin
						ev_q    <= mdb_pkg::EV_CARVED;
						state_q <= S_WR_CUR;
					end else if (!status.stack_empty) begin
						ev_q    <= mdb_pkg::EV_BACK;
						state_q <= S_POP_RD;
					end else begin
						ev_q    <= mdb_pkg::EV_FINISHED;
						state_q <= S_RESP;
					end
				end
				S_WR_CUR:   state_q <= S_WR_NBR;
				S_WR_NBR:   state_q <= S_RESP;
				S_POP_RD:   state_q <= S_POP_LD;
				S_POP_LD:   state_q <= S_RESP;
				S_RD_CELL:  state_q <= S_CAP_CELL;
				S_CAP_CELL: state_q <= S_RESP;
				S_RESP: begin
					if (!status.out_busy) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.rd_sel    = mdb_pkg::RD_NONE;
		cmd.cap_sel   = mdb_pkg::CAP_NONE;
		cmd.wr_sel    = mdb_pkg::WR_NONE;
		cmd.ev        = ev_q;
		cmd.load_item = accept;
		case (state_q)
			S_DECODE:   cmd.init = (status.command == mdb_pkg::CMD_START);
			S_CLEAR:    cmd.wr_sel = mdb_pkg::WR_CLEAR;
			S_RD_A:     cmd.rd_sel = mdb_pkg::RD_CUR_LEFT;
			S_RD_B: begin
				cmd.rd_sel  = mdb_pkg::RD_RIGHT_UP;
				cmd.cap_sel = mdb_pkg::CAP_CUR_LEFT;
			end
			S_RD_C: begin
				cmd.rd_sel  = mdb_pkg::RD_DOWN;
				cmd.cap_sel = mdb_pkg::CAP_RIGHT_UP;
			end
			S_CAP:      cmd.cap_sel = mdb_pkg::CAP_DOWN;
			S_EVAL:     cmd.eval = 1'b1;
			S_BRANCH:   cmd.set_fin = !status.any_opt && status.stack_empty;
			S_WR_CUR:   cmd.wr_sel = mdb_pkg::WR_CUR;
			S_WR_NBR:   cmd.wr_sel = mdb_pkg::WR_NBR;
			S_POP_RD:   cmd.pop_rd = 1'b1;
			S_POP_LD:   cmd.pop_ld = 1'b1;
			S_RD_CELL:  cmd.rd_sel = mdb_pkg::RD_CELL;
			S_CAP_CELL: cmd.cap_sel = mdb_pkg::CAP_CUR_LEFT;
			S_RESP:     cmd.out_load = !status.out_busy;
			default: begin
			end
		endcase
	end

endmodule

// File: design/maze_dfs_backtracker_unit.sv
// Top level of the depth-first backtracking maze generator.
// Depends on mdb_pkg, mdb_stream_if, mdb_controller and mdb_datapath.
//
//   Channel   Kind              Beat contents
//   request   stream, sink      command, random_word, read_x, read_y
//   result    stream, source    event_res, cell_x, cell_y, direction, walls, done_res
//   apb       register port     side_length at byte address 0
//
// A step reads the current cell and its four neighbours over the two read ports of the cell
// store, then carves through the single write port, backtracks, or finds no way forward and
// an empty path stack. A read inside the maze reads its cell; a read outside it, an ignored
// step, a step after the finish and an unused command do not touch the cell store. A start
// sweeps the whole cell store, one cell a cycle, and no request is taken meanwhile.
// A result waiting in the output register does not hold back the next request; only the
// delivery of the following result waits for it. Reset is asynchronous and active low.
module maze_dfs_backtracker_unit #(
	parameter int MAX_SIDE = mdb_pkg::DEF_MAX_SIDE
) (
	input  logic        clk,
	input  logic        arst_n,
	mdb_stream_if.sink   request,
	mdb_stream_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mdb_pkg::ctrl_cmd_t  cmd;
	mdb_pkg::dp_status_t status;
	logic [5:0]          side_length_q;
	logic                reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == mdb_pkg::REG_SIDE_LENGTH);
	assign prdata  = reg_hit ? {26'd0, side_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_length_q <= mdb_pkg::SIDE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			side_length_q <= pwdata[5:0];
		end
	end

	mdb_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mdb_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.side_length (side_length_q),
		.req_data    (request.data),
		.rsp_data    (result.data),
		.rsp_valid   (result.valid),
		.rsp_ready   (result.ready)
	);

endmodule

// File: bench/tb_maze_dfs_backtracker_unit.sv
// Self-checking testbench for the depth-first backtracking maze generator: a directed table
// of beats, then random generation over many sides, checked by a predictor or the table.
// Depends on mdb_pkg, mdb_stream_if and the RTL of maze_dfs_backtracker_unit.
module tb_maze_dfs_backtracker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID = mdb_pkg::DEF_MAX_SIDE;
	localparam int CELLS = GRID * GRID;
	localparam int VISIT_BIT = 4;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int ITEM_TARGET = 1300;
	localparam int PHASE_CAP = 420;
	localparam logic [2:0] SIDE_ADDR = {mdb_pkg::REG_SIDE_LENGTH, 2'b00};
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		bit            side_write;
		logic [5:0]    side;
		mdb_pkg::req_t beat;
		bit            typed;
		mdb_pkg::rsp_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mdb_stream_if #(.payload_t(mdb_pkg::req_t)) req_if ();
	mdb_stream_if #(.payload_t(mdb_pkg::rsp_t)) res_if ();

	maze_dfs_backtracker_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: wall bits plus visited mark per cell, and the path back to the start.
	logic [4:0]  grid [CELLS];
	logic [9:0]  trail [CELLS];
	int unsigned trail_len = 0;
	logic [4:0]  cur_x = '0;
	logic [4:0]  cur_y = '0;
	bit          started = 1'b0;
	bit          gen_done = 1'b0;
	logic [5:0]  side_reg = mdb_pkg::SIDE_RESET;
	int unsigned side_live = GRID;

	mdb_pkg::rsp_t awaited_events [$];
	int   mismatches = 0;
	int   stalled_cycles = 0;
	int   src_idle_pct = 35;
	int   sink_idle_pct = 35;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic mdb_pkg::rsp_t advance_maze(input mdb_pkg::req_t r);
		mdb_pkg::rsp_t o;
		int unsigned   idx;
		int unsigned   nidx;
		int unsigned   n;
		logic [1:0]    opts [4];
		logic [1:0]    d;
		o = '0;
		o.cell_x = cur_x;
		o.cell_y = cur_y;
		case (r.command)
			mdb_pkg::CMD_START: begin
				side_live = (side_reg == 0) ? 1 : (side_reg > GRID) ? GRID : side_reg;
				for (int i = 0; i < CELLS; i++) grid[i] = {1'b0, mdb_pkg::ALL_WALLS};
				grid[0][VISIT_BIT] = 1'b1;
				trail_len = 0;
				cur_x = '0;
				cur_y = '0;
				started = 1'b1;
				gen_done = 1'b0;
				o.event_res = mdb_pkg::EV_CLEARED;
				o.cell_x = '0;
				o.cell_y = '0;
			end
			mdb_pkg::CMD_STEP: begin
				if (!started) begin
					o.event_res = mdb_pkg::EV_IGNORED;
				end else if (gen_done) begin
					o.event_res = mdb_pkg::EV_FINISHED;
				end else begin
					idx = cur_y * GRID + cur_x;
					n = 0;
					if (grid[idx][mdb_pkg::DIR_LEFT] && cur_x > 0
					    && !grid[idx - 1][VISIT_BIT]) begin
						opts[n] = mdb_pkg::DIR_LEFT;
						n++;
					end
					if (grid[idx][mdb_pkg::DIR_RIGHT] && cur_x + 1 < side_live
					    && !grid[idx + 1][VISIT_BIT]) begin
						opts[n] = mdb_pkg::DIR_RIGHT;
						n++;
					end
					if (grid[idx][mdb_pkg::DIR_UP] && cur_y > 0
					    && !grid[idx - GRID][VISIT_BIT]) begin
						opts[n] = mdb_pkg::DIR_UP;
						n++;
					end
					if (grid[idx][mdb_pkg::DIR_DOWN] && cur_y + 1 < side_live
					    && !grid[idx + GRID][VISIT_BIT]) begin
						opts[n] = mdb_pkg::DIR_DOWN;
						n++;
					end
					if (n > 0) begin
						d = opts[r.random_word % n];
						case (d)
							mdb_pkg::DIR_LEFT:  nidx = idx - 1;
							mdb_pkg::DIR_RIGHT: nidx = idx + 1;
							mdb_pkg::DIR_UP:    nidx = idx - GRID;
							default:            nidx = idx + GRID;
						endcase
						grid[idx][d] = 1'b0;
						grid[nidx][d ^ 2'd1] = 1'b0;
						grid[nidx][VISIT_BIT] = 1'b1;
						if (trail_len < CELLS) begin
							trail[trail_len] = 10'(idx);
							trail_len++;
						end
						cur_x = 5'(nidx % GRID);
						cur_y = 5'(nidx / GRID);
						o.event_res = mdb_pkg::EV_CARVED;
						o.direction = d;
					end else if (trail_len > 0) begin
						trail_len--;
						cur_x = 5'(trail[trail_len] % GRID);
						cur_y = 5'(trail[trail_len] / GRID);
						o.event_res = mdb_pkg::EV_BACK;
					end else begin
						gen_done = 1'b1;
						o.event_res = mdb_pkg::EV_FINISHED;
					end
					o.cell_x = cur_x;
					o.cell_y = cur_y;
				end
			end
			mdb_pkg::CMD_READ: begin
				o.event_res = mdb_pkg::EV_READ;
				o.cell_x = r.read_x;
				o.cell_y = r.read_y;
				if (r.read_x < side_live && r.read_y < side_live)
					o.walls = grid[r.read_y * GRID + r.read_x][3:0];
			end
			default: o.event_res = mdb_pkg::EV_IGNORED;
		endcase
		o.done_res = gen_done;
		return o;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) $display("%0t ns: %s", $time, what);
	endtask

	task automatic send_beat(input mdb_pkg::req_t r, input bit typed, input mdb_pkg::rsp_t want);
		mdb_pkg::rsp_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		predicted = advance_maze(r);
		awaited_events.push_back(typed ? want : predicted);
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		while (awaited_events.size() != 0) @(posedge clk);
	endtask

	task automatic set_side(input logic [5:0] s);
		logic [31:0] wdat;
		logic [31:0] back;
		wdat = $urandom();
		wdat[5:0] = s;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SIDE_ADDR;
		pwdata <= wdat;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		side_reg = s;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		back = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (back !== 32'(s))
			report_mismatch($sformatf("side_length reads back %h after writing %h", back, s));
	endtask

	function automatic plan_row_t side_row(input logic [5:0] s);
		plan_row_t p;
		p.side_write = 1'b1;
		p.side = s;
		p.beat = '0;
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	function automatic plan_row_t beat_row(input logic [1:0] c, input logic [31:0] w,
	                                       input logic [4:0] x, input logic [4:0] y);
		plan_row_t p;
		p.side_write = 1'b0;
		p.side = '0;
		p.beat = '{c, w, x, y};
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	function automatic plan_row_t known_row(input logic [1:0] c, input logic [31:0] w,
	                                        input logic [4:0] x, input logic [4:0] y,
	                                        input logic [2:0] ev, input logic [4:0] cx,
	                                        input logic [4:0] cy, input logic [1:0] dir,
	                                        input logic [3:0] wl, input logic dn);
		plan_row_t p;
		p = beat_row(c, w, x, y);
		p.typed = 1'b1;
		p.want = '{ev, cx, cy, dir, wl, dn};
		return p;
	endfunction

	always @(posedge clk) res_if.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		mdb_pkg::rsp_t want;
		mdb_pkg::rsp_t got;
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
			    || (psel && penable))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				if (awaited_events.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing awaited: ev %0d (%0d,%0d)",
					                          got.event_res, got.cell_x, got.cell_y));
				end else begin
					want = awaited_events.pop_front();
					if (got !== want)
						report_mismatch($sformatf(
							"got/exp ev %0d/%0d x %0d/%0d y %0d/%0d dir %0d/%0d walls %h/%h done %0d/%0d",
							got.event_res, want.event_res, got.cell_x, want.cell_x,
							got.cell_y, want.cell_y, got.direction, want.direction,
							got.walls, want.walls, got.done_res, want.done_res));
				end
			end
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("maze_dfs_backtracker_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t     plan [$];
		mdb_pkg::req_t beat;
		int unsigned   counted;
		int unsigned   phase_items;
		int unsigned   tail;
		int unsigned   pick;
		logic [5:0]    s;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(known_row(mdb_pkg::CMD_STEP, 32'h0, 5'd0, 5'd0,
		                         mdb_pkg::EV_IGNORED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(known_row(CMD_UNUSED, '1, 5'd31, 5'd31,
		                         mdb_pkg::EV_IGNORED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(side_row(6'd1));
		plan.push_back(known_row(mdb_pkg::CMD_START, '1, 5'd31, 5'd31,
		                         mdb_pkg::EV_CLEARED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(known_row(mdb_pkg::CMD_READ, 32'h0, 5'd0, 5'd0,
		                         mdb_pkg::EV_READ, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, mdb_pkg::ALL_WALLS, 1'b0));
		plan.push_back(known_row(mdb_pkg::CMD_READ, 32'h0, 5'd31, 5'd31,
		                         mdb_pkg::EV_READ, 5'd31, 5'd31,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(known_row(mdb_pkg::CMD_STEP, 32'h0, 5'd0, 5'd0,
		                         mdb_pkg::EV_FINISHED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b1));
		plan.push_back(known_row(mdb_pkg::CMD_STEP, '1, 5'd0, 5'd0,
		                         mdb_pkg::EV_FINISHED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b1));
		plan.push_back(known_row(CMD_UNUSED, 32'h0, 5'd7, 5'd9,
		                         mdb_pkg::EV_IGNORED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b1));
		plan.push_back(side_row(6'd2));
		plan.push_back(known_row(mdb_pkg::CMD_READ, 32'h0, 5'd1, 5'd0,
		                         mdb_pkg::EV_READ, 5'd1, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b1));
		plan.push_back(known_row(mdb_pkg::CMD_START, 32'h0, 5'd0, 5'd0,
		                         mdb_pkg::EV_CLEARED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, 32'h0, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, '1, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, 32'h0, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_READ, 32'h0, 5'd1, 5'd1));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, '1, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, 32'h8000_0000, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, 32'h1, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, 32'h0, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_READ, 32'h0, 5'd0, 5'd1));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, '1, 5'd0, 5'd0));
		plan.push_back(side_row(6'd0));
		plan.push_back(known_row(mdb_pkg::CMD_START, 32'h0, 5'd0, 5'd0,
		                         mdb_pkg::EV_CLEARED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(known_row(mdb_pkg::CMD_STEP, 32'h5, 5'd0, 5'd0,
		                         mdb_pkg::EV_FINISHED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b1));
		plan.push_back(side_row(6'h3f));
		plan.push_back(known_row(mdb_pkg::CMD_START, 32'h0, 5'd0, 5'd0,
		                         mdb_pkg::EV_CLEARED, 5'd0, 5'd0,
		                         mdb_pkg::DIR_LEFT, 4'h0, 1'b0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, '1, 5'd0, 5'd0));
		plan.push_back(beat_row(mdb_pkg::CMD_STEP, 32'h2, 5'd0, 5'd0));
		plan.push_back(known_row(mdb_pkg::CMD_READ, 32'h0, 5'd31, 5'd31,
		                         mdb_pkg::EV_READ, 5'd31, 5'd31,
		                         mdb_pkg::DIR_LEFT, mdb_pkg::ALL_WALLS, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].side_write) begin
				settle();
				set_side(plan[i].side);
			end else begin
				send_beat(plan[i].beat, plan[i].typed, plan[i].want);
			end
		end

		counted = 0;
		while (counted < ITEM_TARGET) begin
			settle();
			pick = $urandom_range(99);
			if (pick < 6) s = 6'd0;
			else if (pick < 14) s = 6'd32;
			else if (pick < 18) s = 6'h3f;
			else if (pick < 24) s = 6'($urandom_range(33, 62));
			else if (pick < 40) s = 6'($urandom_range(11, 31));
			else s = 6'($urandom_range(1, 10));
			set_side(s);
			beat = '0;
			beat.command = mdb_pkg::CMD_START;
			beat.random_word = $urandom();
			send_beat(beat, 1'b0, '0);
			counted++;
			tail = $urandom_range(1, 3);
			phase_items = 0;
			while (phase_items < PHASE_CAP && tail > 0) begin
				src_idle_pct = (counted >= 500 && counted < 800) ? 0 : 35;
				sink_idle_pct = src_idle_pct;
				beat.random_word = $urandom();
				beat.read_x = 5'($urandom_range(0, 31));
				beat.read_y = 5'($urandom_range(0, 31));
				pick = $urandom_range(99);
				if (pick < 20) begin
					beat.command = mdb_pkg::CMD_READ;
					if ($urandom_range(9) != 0) begin
						beat.read_x = 5'($urandom_range(0, side_live - 1));
						beat.read_y = 5'($urandom_range(0, side_live - 1));
					end
				end else if (pick < 23) begin
					beat.command = CMD_UNUSED;
				end else if (pick < 24) begin
					beat.command = mdb_pkg::CMD_START;
				end else begin
					beat.command = mdb_pkg::CMD_STEP;
					pick = $urandom_range(9);
					if (pick == 0) beat.random_word = '1;
					else if (pick == 1) beat.random_word = '0;
					else if (pick < 4) beat.random_word = $urandom_range(0, 7);
				end
				send_beat(beat, 1'b0, '0);
				if (beat.command != CMD_UNUSED) counted++;
				phase_items++;
				if (gen_done) tail--;
			end
			if ($urandom_range(3) == 0) begin
				settle();
				set_side(6'($urandom()));
				repeat (3) begin
					beat.command = mdb_pkg::CMD_READ;
					beat.random_word = $urandom();
					beat.read_x = 5'($urandom_range(0, 31));
					beat.read_y = 5'($urandom_range(0, 31));
					send_beat(beat, 1'b0, '0);
					counted++;
				end
			end
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("maze_dfs_backtracker_unit: match");
		else
			$display("maze_dfs_backtracker_unit: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/mdb_pkg.sv
design/mdb_stream_if.sv
design/mdb_datapath.sv
design/mdb_controller.sv
design/maze_dfs_backtracker_unit.sv
bench/tb_maze_dfs_backtracker_unit.sv
